// File: src/tws_pkg.sv
// Shared constants for the tube wall-or-exit step pipeline.
`timescale 1ns / 1ps

package tws_pkg;

   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam int RADIUS_BITS   = 31;
   localparam int START_BITS    = 32;
   localparam int LENGTH_BITS   = 31;
   localparam int EVENT_BITS    = 2;
   localparam int DIGIT_BITS    = 8;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_START  = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LENGTH = 2'd2;

   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 31'd412876;
   localparam logic [START_BITS-1:0]  START_RESET  = 32'd0;
   localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 31'd8486912;

   localparam logic [EVENT_BITS-1:0] EV_WALL   = 2'd0;
   localparam logic [EVENT_BITS-1:0] EV_PLANE  = 2'd1;
   localparam logic [EVENT_BITS-1:0] EV_NOROOT = 2'd2;
   localparam logic [EVENT_BITS-1:0] EV_STILL  = 2'd3;

endpackage

// File: src/tws_if.sv
// Request, response and register-write channel interfaces.
`timescale 1ns / 1ps

interface tws_req_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] pos_x;
   logic signed [COORD_WIDTH-1:0] pos_y;
   logic signed [COORD_WIDTH-1:0] pos_z;
   logic signed [COORD_WIDTH-1:0] vel_x;
   logic signed [COORD_WIDTH-1:0] vel_y;
   logic signed [COORD_WIDTH-1:0] vel_z;
   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface tws_rsp_if #(parameter int COORD_WIDTH = 32);
   logic                               valid;
   logic                               ready;
   logic signed [COORD_WIDTH-1:0]      new_x;
   logic signed [COORD_WIDTH-1:0]      new_y;
   logic signed [COORD_WIDTH-1:0]      new_z;
   logic [tws_pkg::EVENT_BITS-1:0]     event_res;
   modport source (output valid, new_x, new_y, new_z, event_res, input ready);
   modport sink   (input valid, new_x, new_y, new_z, event_res, output ready);
endinterface

interface tws_csr_if;
   logic                              valid;
   logic                              ready;
   logic [tws_pkg::CSR_ADDR_BITS-1:0] index;
   logic [tws_pkg::CSR_DATA_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: src/tws_delay.sv
// Enabled shift line that keeps side data aligned with the pipeline.
`timescale 1ns / 1ps

module tws_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

// File: src/tws_mul.sv
// Pipelined signed multiplier, one 8-bit digit of the second operand per stage.
`timescale 1ns / 1ps

module tws_mul #(
   parameter int A_W = 32,
   parameter int B_W = 32
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [A_W-1:0]       op_a,
   input  logic signed [B_W-1:0]       op_b,
   output logic signed [A_W+B_W-1:0]   prod
);

   localparam int DG = tws_pkg::DIGIT_BITS;
   localparam int ND = (B_W + DG - 1) / DG;
   localparam int BE = ND * DG;
   localparam int P  = A_W + BE;

   logic signed [A_W-1:0] a_ff   [ND-1];
   logic [BE-1:0]         b_ff   [ND-1];
   logic [P-1:0]          acc_ff [ND];
   logic [BE-1:0]         b_ext;

   assign b_ext = BE'(op_b);

   for (genvar k = 0; k < ND; k++) begin : g_dig
      logic signed [A_W-1:0]  a_src;
      logic [BE-1:0]          b_src;
      logic [P-1:0]           acc_src;
      logic signed [DG:0]     dig;
      logic signed [A_W+DG:0] pp;
      logic [P-1:0]           acc_in;

      if (k == 0) begin : g_head
         assign a_src   = op_a;
         assign b_src   = b_ext;
         assign acc_src = '0;
      end else begin : g_tail
         assign a_src   = a_ff[k-1];
         assign b_src   = b_ff[k-1];
         assign acc_src = acc_ff[k-1];
      end

      // top digit carries the sign weight
      if (k == ND - 1) begin : g_top
         assign dig = $signed({b_src[k*DG+DG-1], b_src[k*DG +: DG]});
      end else begin : g_low
         assign dig = $signed({1'b0, b_src[k*DG +: DG]});
      end

      assign pp     = a_src * dig;
      assign acc_in = acc_src + (P'(pp) << (k * DG));

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= acc_in;
         end
      end

      if (k < ND - 1) begin : g_pass
         always_ff @(posedge clock) begin
            if (en) begin
               a_ff[k] <= a_src;
               b_ff[k] <= b_src;
            end
         end
      end
   end

   assign prod = $signed(acc_ff[ND-1][A_W+B_W-1:0]);

endmodule

// File: src/tws_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps

module tws_sqrt #(
   parameter int RW = 128
) (
   input  logic              clock,
   input  logic              en,
   input  logic [RW-1:0]     radicand,
   output logic [RW/2-1:0]   root
);

   localparam int NS  = RW / 2;
   localparam int RMW = NS + 3;

   logic [NS-1:0]  root_ff [NS];
   logic [RMW-1:0] rem_ff  [NS-1];
   logic [RW-1:0]  rad_ff  [NS-1];

   for (genvar k = 0; k < NS; k++) begin : g_bit
      logic [NS-1:0]  root_src;
      logic [RMW-1:0] rem_src;
      logic [RW-1:0]  rad_src;
      logic [RMW-1:0] part;
      logic [RMW-1:0] trial;
      logic           ge;
      logic [RMW-1:0] rem_in;
      logic [NS-1:0]  root_in;

      if (k == 0) begin : g_head
         assign root_src = '0;
         assign rem_src  = '0;
         assign rad_src  = radicand;
      end else begin : g_tail
         assign root_src = root_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign rad_src  = rad_ff[k-1];
      end

      assign part    = {rem_src[RMW-3:0], rad_src[RW-1 -: 2]};
      assign trial   = RMW'({root_src, 2'b01});
      assign ge      = part >= trial;
      assign rem_in  = ge ? part - trial : part;
      assign root_in = {root_src[NS-2:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[k] <= root_in;
         end
      end

      if (k < NS - 1) begin : g_pass
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               rad_ff[k] <= rad_src << 2;
            end
         end
      end
   end

   assign root = root_ff[NS-1];

endmodule

// File: src/tws_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module tws_div #(
   parameter int N = 81,
   parameter int M = 64
) (
   input  logic          clock,
   input  logic          en,
   input  logic [N-1:0]  dividend,
   input  logic [M-1:0]  divisor,
   output logic [N-1:0]  quo,
   output logic          rem_nz
);

   logic [N-1:0] q_ff   [N];
   logic [M-1:0] rem_ff [N];
   logic [N-1:0] dvd_ff [N-1];
   logic [M-1:0] d_ff   [N-1];

   for (genvar k = 0; k < N; k++) begin : g_bit
      logic [N-1:0] q_src;
      logic [M-1:0] rem_src;
      logic [N-1:0] dvd_src;
      logic [M-1:0] d_src;
      logic [M:0]   part;
      logic [M:0]   diff;
      logic         ge;

      if (k == 0) begin : g_head
         assign q_src   = '0;
         assign rem_src = '0;
         assign dvd_src = dividend;
         assign d_src   = divisor;
      end else begin : g_tail
         assign q_src   = q_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign dvd_src = dvd_ff[k-1];
         assign d_src   = d_ff[k-1];
      end

      assign part = {rem_src, dvd_src[N-1]};
      assign diff = part - {1'b0, d_src};
      assign ge   = part >= {1'b0, d_src};

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k]   <= {q_src[N-2:0], ge};
            rem_ff[k] <= ge ? diff[M-1:0] : part[M-1:0];
         end
      end

      if (k < N - 1) begin : g_pass
         always_ff @(posedge clock) begin
            if (en) begin
               dvd_ff[k] <= dvd_src << 1;
               d_ff[k]   <= d_src;
            end
         end
      end
   end

   assign quo    = q_ff[N-1];
   assign rem_nz = |rem_ff[N-1];

endmodule

// File: src/tube_wall_or_exit_step_top.sv
// Top level: straight-line particle step to the tube wall or an end plane.
// Widths: CW = max(W,32), NQ = max(2*CW+1+F, max(W,33)+1+F); L1/L2/L3 = multiplier
//   digit counts of CW, 2*CW+2 and NQ+2 bits over 8.
// Throughput: one request per cycle unless the full response register stalls the pipe;
//   the sqrt and divider pipelines make up most of the depth.
// Reset (synchronous): empties the pipeline and response register, loads defaults, no accepts.
`timescale 1ns / 1ps

module tube_wall_or_exit_step_top #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input logic         clock,
   input logic         reset,
   tws_req_if.sink     req_ch,
   tws_rsp_if.source   rsp_ch,
   tws_csr_if.sink     csr_ch
);

   localparam int W   = COORD_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int DG  = tws_pkg::DIGIT_BITS;
   localparam int CW  = (W > 32) ? W : 32;           // width that also holds the radius
   localparam int AW  = 2 * CW + 2;                  // a, b, c of the quadratic
   localparam int PW  = ((W > 33) ? W : 33) + 1;     // plane minus z
   localparam int NW  = 2 * CW + 1 + F;              // wall time dividend
   localparam int XW  = PW + F;                      // axial time dividend
   localparam int NQ  = (NW > XW) ? NW : XW;         // shared divider width
   localparam int TW  = NQ + 2;                      // signed event time
   localparam int SW  = W + TW + 1;
   localparam int L1  = (CW + DG - 1) / DG;
   localparam int L2  = (AW + DG - 1) / DG;
   localparam int LS  = 2 * CW;
   localparam int L3  = (TW + DG - 1) / DG;
   localparam int VL  = L1 + L2 + LS + NQ + L3 + 5;

   localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   // ---------------- register file ----------------
   logic [tws_pkg::RADIUS_BITS-1:0]        radius_ff;
   logic signed [tws_pkg::START_BITS-1:0]  start_ff;
   logic [tws_pkg::LENGTH_BITS-1:0]        length_ff;

   // no write is taken while reset holds the defaults
   assign csr_ch.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= tws_pkg::RADIUS_RESET;
         start_ff  <= tws_pkg::START_RESET;
         length_ff <= tws_pkg::LENGTH_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            tws_pkg::CSR_RADIUS: radius_ff <= csr_ch.data[tws_pkg::RADIUS_BITS-1:0];
            tws_pkg::CSR_START:  start_ff  <= csr_ch.data[tws_pkg::START_BITS-1:0];
            tws_pkg::CSR_LENGTH: length_ff <= csr_ch.data[tws_pkg::LENGTH_BITS-1:0];
            default: ;  // unknown index ignored
         endcase
      end
   end

   // ---------------- flow control ----------------
   // The whole pipe moves in lockstep; it only holds when its last slot is
   // full and the response register cannot take it.
   logic          vld_ff [VL];
   logic          out_vld_ff;
   logic          en;
   logic          out_load;

   assign en           = !(vld_ff[VL-1] && out_vld_ff && !rsp_ch.ready);
   assign out_load     = en && vld_ff[VL-1];
   assign req_ch.ready = en && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VL; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_ch.valid;
         for (int i = 1; i < VL; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // ---------------- stage 0: request capture ----------------
   logic signed [W-1:0] x0_ff, y0_ff, z0_ff, vx0_ff, vy0_ff, vz0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff  <= req_ch.pos_x;
         y0_ff  <= req_ch.pos_y;
         z0_ff  <= req_ch.pos_z;
         vx0_ff <= req_ch.vel_x;
         vy0_ff <= req_ch.vel_y;
         vz0_ff <= req_ch.vel_z;
      end
   end

   // ---------------- first products ----------------
   logic signed [CW-1:0]   xc, yc, vxc, vyc, rc;
   logic signed [2*CW-1:0] xx, yy, vxx, vyy, xvx, yvy, rr;

   assign xc  = CW'(x0_ff);
   assign yc  = CW'(y0_ff);
   assign vxc = CW'(vx0_ff);
   assign vyc = CW'(vy0_ff);
   assign rc  = CW'($signed({1'b0, radius_ff}));

   tws_mul #(.A_W(CW), .B_W(CW)) u_mul_xx  (.clock, .en, .op_a(xc),  .op_b(xc),  .prod(xx));
   tws_mul #(.A_W(CW), .B_W(CW)) u_mul_yy  (.clock, .en, .op_a(yc),  .op_b(yc),  .prod(yy));
   tws_mul #(.A_W(CW), .B_W(CW)) u_mul_vxx (.clock, .en, .op_a(vxc), .op_b(vxc), .prod(vxx));
   tws_mul #(.A_W(CW), .B_W(CW)) u_mul_vyy (.clock, .en, .op_a(vyc), .op_b(vyc), .prod(vyy));
   tws_mul #(.A_W(CW), .B_W(CW)) u_mul_xvx (.clock, .en, .op_a(xc),  .op_b(vxc), .prod(xvx));
   tws_mul #(.A_W(CW), .B_W(CW)) u_mul_yvy (.clock, .en, .op_a(yc),  .op_b(vyc), .prod(yvy));
   tws_mul #(.A_W(CW), .B_W(CW)) u_mul_rr  (.clock, .en, .op_a(rc),  .op_b(rc),  .prod(rr));

   // ---------------- stage 1: quadratic coefficients ----------------
   logic signed [AW-1:0] a1_ff, b1_ff, c1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff <= AW'(vxx) + AW'(vyy);
         b1_ff <= AW'(xvx) + AW'(yvy);
         c1_ff <= AW'(xx) + AW'(yy) - AW'(rr);
      end
   end

   // ---------------- discriminant ----------------
   logic signed [2*AW-1:0] bb, ac;
   logic signed [2*AW-1:0] d2_ff;

   tws_mul #(.A_W(AW), .B_W(AW)) u_mul_bb (.clock, .en, .op_a(b1_ff), .op_b(b1_ff), .prod(bb));
   tws_mul #(.A_W(AW), .B_W(AW)) u_mul_ac (.clock, .en, .op_a(a1_ff), .op_b(c1_ff), .prod(ac));

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff <= bb - ac;
      end
   end

   // ---------------- square root, side data alongside ----------------
   logic [2*CW-1:0]   s3;
   logic [2*AW-1:0]   ab3;
   logic              dneg3;
   logic [6*W-1:0]    pay3;

   // D is below 2^(4CW-1) whenever it is not negative
   tws_sqrt #(.RW(4 * CW)) u_sqrt (
      .clock, .en, .radicand(d2_ff[4*CW-1:0]), .root(s3)
   );

   tws_delay #(.WIDTH(2 * AW), .DEPTH(L2 + 1 + LS)) u_dly_ab (
      .clock, .en, .din({a1_ff, b1_ff}), .dout(ab3)
   );
   tws_delay #(.WIDTH(1), .DEPTH(LS)) u_dly_dneg (
      .clock, .en, .din(d2_ff[2*AW-1]), .dout(dneg3)
   );
   tws_delay #(.WIDTH(6 * W), .DEPTH(L1 + 1 + L2 + 1 + LS)) u_dly_pay (
      .clock, .en, .din({x0_ff, y0_ff, z0_ff, vx0_ff, vy0_ff, vz0_ff}), .dout(pay3)
   );

   // ---------------- stage 3: roots and dividends ----------------
   logic signed [AW-1:0]   a3, b3;
   logic signed [W-1:0]    z3, vx3, vy3, vz3;
   logic signed [2*CW+1:0] sx3, n1, n2, nsel;
   logic                   noroot3, radial3, axial3;
   logic signed [PW-1:0]   plane3, diff3;
   logic [PW-1:0]          dmag3;
   logic [W-1:0]           vzm3;

   assign a3  = $signed(ab3[2*AW-1:AW]);
   assign b3  = $signed(ab3[AW-1:0]);
   assign z3  = $signed(pay3[4*W-1:3*W]);
   assign vx3 = $signed(pay3[3*W-1:2*W]);
   assign vy3 = $signed(pay3[2*W-1:W]);
   assign vz3 = $signed(pay3[W-1:0]);

   assign sx3     = $signed({2'b00, s3});
   assign n1      = sx3 - b3;   // later root
   assign n2      = -sx3 - b3;  // earlier root
   assign nsel    = (!n2[2*CW+1] && (n2 != '0)) ? n2 : n1;
   assign noroot3 = dneg3 || n1[2*CW+1];
   assign radial3 = (vx3 != '0) || (vy3 != '0);
   assign axial3  = vz3 != '0;

   // exit plane when moving forward, entry plane when moving back
   assign plane3 = PW'(start_ff) +
                   ((!vz3[W-1] && axial3) ? PW'($signed({1'b0, length_ff})) : PW'(0));
   assign diff3  = plane3 - PW'(z3);
   assign dmag3  = diff3[PW-1] ? -diff3 : diff3;
   assign vzm3   = vz3[W-1] ? -vz3 : vz3;

   logic [NQ-1:0]   wdvd3_ff, advd3_ff;
   logic [2*CW-1:0] wdiv3_ff, adiv3_ff;
   logic [3:0]      flg3_ff;   // noroot, radial, axial, axial time negative
   logic [6*W-1:0]  pay3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         wdvd3_ff <= NQ'({nsel[2*CW:0], {F{1'b0}}});
         advd3_ff <= NQ'({dmag3, {F{1'b0}}});
         wdiv3_ff <= a3[2*CW-1:0];
         adiv3_ff <= (2*CW)'(vzm3);
         flg3_ff  <= {noroot3, radial3, axial3, diff3[PW-1] ^ vz3[W-1]};
         pay3_ff  <= pay3;
      end
   end

   // ---------------- event times ----------------
   logic [NQ-1:0]       qw4, qa4;
   logic                rnzw4, rnza4;
   logic [4+6*W-1:0]    fp4;

   tws_div #(.N(NQ), .M(2 * CW)) u_div_wall (
      .clock, .en, .dividend(wdvd3_ff), .divisor(wdiv3_ff), .quo(qw4), .rem_nz(rnzw4)
   );
   tws_div #(.N(NQ), .M(2 * CW)) u_div_axial (
      .clock, .en, .dividend(advd3_ff), .divisor(adiv3_ff), .quo(qa4), .rem_nz(rnza4)
   );
   tws_delay #(.WIDTH(4 + 6 * W), .DEPTH(NQ)) u_dly_fp (
      .clock, .en, .din({flg3_ff, pay3_ff}), .dout(fp4)
   );

   // ---------------- stage 4: event choice ----------------
   logic                          noroot4, radial4, axial4, tzneg4, wall4;
   logic signed [TW-1:0]          tr4, tz4, t4;
   logic [NQ:0]                   tzm4;
   logic [tws_pkg::EVENT_BITS-1:0] ev4;

   assign {noroot4, radial4, axial4, tzneg4} = fp4[4+6*W-1:6*W];
   assign wall4 = radial4 && !noroot4;
   assign tr4   = $signed({2'b00, qw4});
   // floor division: a negative quotient rounds away from zero on a remainder
   assign tzm4  = {1'b0, qa4} + (NQ+1)'(rnza4 && tzneg4);
   assign tz4   = tzneg4 ? -$signed({1'b0, tzm4}) : $signed({1'b0, tzm4});

   always_comb begin
      if (radial4 && noroot4) begin
         ev4 = tws_pkg::EV_NOROOT;
      end else if (!wall4 && !axial4) begin
         ev4 = tws_pkg::EV_STILL;
      end else if (wall4 && (!axial4 || (tr4 < tz4))) begin
         ev4 = tws_pkg::EV_WALL;
      end else begin
         ev4 = tws_pkg::EV_PLANE;
      end
      // zero time leaves the position as it came in
      case (ev4)
         tws_pkg::EV_WALL:  t4 = tr4;
         tws_pkg::EV_PLANE: t4 = tz4;
         default:           t4 = '0;
      endcase
   end

   logic signed [TW-1:0]           t4_ff;
   logic [tws_pkg::EVENT_BITS-1:0] ev4_ff;
   logic [3*W-1:0]                 pos4_ff, vel4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t4_ff   <= t4;
         ev4_ff  <= ev4;
         pos4_ff <= fp4[6*W-1:3*W];
         vel4_ff <= fp4[3*W-1:0];
      end
   end

   // ---------------- advance ----------------
   logic signed [W+TW-1:0]          mx5, my5, mz5;
   logic [3*W+tws_pkg::EVENT_BITS-1:0] pe5;

   tws_mul #(.A_W(W), .B_W(TW)) u_mul_mx (
      .clock, .en, .op_a($signed(vel4_ff[3*W-1:2*W])), .op_b(t4_ff), .prod(mx5)
   );
   tws_mul #(.A_W(W), .B_W(TW)) u_mul_my (
      .clock, .en, .op_a($signed(vel4_ff[2*W-1:W])), .op_b(t4_ff), .prod(my5)
   );
   tws_mul #(.A_W(W), .B_W(TW)) u_mul_mz (
      .clock, .en, .op_a($signed(vel4_ff[W-1:0])), .op_b(t4_ff), .prod(mz5)
   );
   tws_delay #(.WIDTH(3 * W + tws_pkg::EVENT_BITS), .DEPTH(L3)) u_dly_pe (
      .clock, .en, .din({pos4_ff, ev4_ff}), .dout(pe5)
   );

   function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0]    p,
                                                   input logic signed [W+TW-1:0] m);
      logic signed [SW-1:0] sum;
      logic [TW+1:0]        chk;
      sum = SW'(p) + SW'(m >>> F);
      chk = sum[SW-1:W-1];
      if (&chk || ~|chk) begin
         return sum[W-1:0];
      end
      return sum[SW-1] ? MINV : MAXV;
   endfunction

   // ---------------- response register ----------------
   logic signed [W-1:0]            nx_ff, ny_ff, nz_ff;
   logic [tws_pkg::EVENT_BITS-1:0] ev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_load) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         nx_ff <= sat_add($signed(pe5[3*W+tws_pkg::EVENT_BITS-1:2*W+tws_pkg::EVENT_BITS]), mx5);
         ny_ff <= sat_add($signed(pe5[2*W+tws_pkg::EVENT_BITS-1:W+tws_pkg::EVENT_BITS]), my5);
         nz_ff <= sat_add($signed(pe5[W+tws_pkg::EVENT_BITS-1:tws_pkg::EVENT_BITS]), mz5);
         ev_ff <= pe5[tws_pkg::EVENT_BITS-1:0];
      end
   end

   assign rsp_ch.valid     = out_vld_ff;
   assign rsp_ch.new_x     = nx_ff;
   assign rsp_ch.new_y     = ny_ff;
   assign rsp_ch.new_z     = nz_ff;
   assign rsp_ch.event_res = ev_ff;

endmodule
